// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the packed list unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define PLSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Expression must never be true outside reset.
`define PLSD_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== sv/plsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Packed list package
// Types and constants shared by the packed list insert, search and delete unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plsd_pkg;

    localparam int CAPACITY    = 64;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int DATA_W      = 32;
    localparam int OP_W        = 2;
    localparam int ST_W        = 2;
    localparam int POS_W       = 6;
    localparam int COUNT_W     = 7;
    localparam int IN_TDATA_W  = ((OP_W + DATA_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((ST_W + 1 + POS_W + COUNT_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

    typedef struct packed {
        t_status            status;
        logic               found;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] count;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/plsd_ram.sv =====
// ----------------------------------------------------------------------------
// Packed list entry store
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plsd_ram (
    input  wire                             i_clk,
    input  plsd_pkg::t_mem_req              i_req,
    output logic [plsd_pkg::DATA_W-1:0]     o_rdata
);
    import plsd_pkg::*;

    logic [DATA_W-1:0] r_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/plsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Packed list controller
// Sequences insert, scan and compacting shift through the entry store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module plsd_ctrl (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire  [plsd_pkg::OP_W-1:0]       i_op,
    input  wire  [plsd_pkg::DATA_W-1:0]     i_value,
    output plsd_pkg::t_mem_req              o_mem_req,
    input  wire  [plsd_pkg::DATA_W-1:0]     i_rdata,
    output logic                            o_res_valid,
    output plsd_pkg::t_result               o_res,
    input  wire                             i_res_ready
);
    import plsd_pkg::*;

    t_state            r_state, n_state;
    t_op               r_op;
    logic [DATA_W-1:0] r_value;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_rd_idx, n_rd_idx;
    logic              r_pend, n_pend;
    logic [IDX_W-1:0]  r_cmp_idx, n_cmp_idx;
    logic [IDX_W-1:0]  r_wr_idx, n_wr_idx;
    t_result           r_res, n_res;

    logic rd_more;
    logic hit;
    logic drained;

    assign rd_more = (r_rd_idx < r_count);
    assign hit     = r_pend && (i_rdata == r_value);
    assign drained = !r_pend && !rd_more;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (r_op == OP_SEARCH || r_op == OP_DELETE) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_state = (r_op == OP_DELETE) ? S_SHIFT : S_RESULT;
                end else if (drained) begin
                    n_state = S_RESULT;
                end
            end
            S_SHIFT: begin
                if (drained) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_mem_req   = '0;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_pend      = r_pend;
        n_cmp_idx   = r_cmp_idx;
        n_wr_idx    = r_wr_idx;
        n_res       = r_res;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_DISPATCH: begin
                n_rd_idx       = '0;
                n_pend         = 1'b0;
                n_res.status   = ST_OK;
                n_res.found    = 1'b0;
                n_res.position = '0;
                n_res.count    = COUNT_W'(r_count);
                if (r_op == OP_INSERT) begin
                    if (r_count < CNT_W'(CAPACITY)) begin
                        o_mem_req.we    = 1'b1;
                        o_mem_req.waddr = r_count[IDX_W-1:0];
                        o_mem_req.wdata = r_value;
                        n_count         = r_count + 1'b1;
                        n_res.position  = POS_W'(r_count);
                        n_res.count     = COUNT_W'(r_count + 1'b1);
                    end else begin
                        n_res.status = ST_FULL;
                    end
                end
            end
            S_SCAN: begin
                o_mem_req.re    = rd_more;
                o_mem_req.raddr = r_rd_idx[IDX_W-1:0];
                n_pend          = rd_more;
                n_rd_idx        = r_rd_idx + {{(CNT_W-1){1'b0}}, rd_more};
                n_cmp_idx       = r_rd_idx[IDX_W-1:0];
                if (hit) begin
                    n_res.found    = 1'b1;
                    n_res.position = POS_W'(r_cmp_idx);
                    n_wr_idx       = r_cmp_idx;
                    n_rd_idx       = CNT_W'(r_cmp_idx) + 1'b1;
                    n_pend         = 1'b0;
                end else if (drained) begin
                    n_res.status = ST_MISSING;
                end
            end
            S_SHIFT: begin
                o_mem_req.re    = rd_more;
                o_mem_req.raddr = r_rd_idx[IDX_W-1:0];
                n_pend          = rd_more;
                n_rd_idx        = r_rd_idx + {{(CNT_W-1){1'b0}}, rd_more};
                if (r_pend) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = r_wr_idx;
                    o_mem_req.wdata = i_rdata;
                    n_wr_idx        = r_wr_idx + 1'b1;
                end
                if (drained) begin
                    n_count     = r_count - 1'b1;
                    n_res.count = COUNT_W'(r_count - 1'b1);
                end
            end
            S_RESULT: begin
                o_res_valid = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_op    <= t_op'(i_op);
            r_value <= i_value;
        end
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        r_wr_idx  <= n_wr_idx;
        r_res     <= n_res;
    end

    `PLSD_ASSERT_NEVER(a_count_bound, r_count > CNT_W'(CAPACITY), "count beyond capacity")
    `PLSD_ASSERT(a_write_state, o_mem_req.we |-> (r_state == S_DISPATCH || r_state == S_SHIFT),
                 "store written outside insert or shift")
    `PLSD_ASSERT(a_shift_range, (r_state == S_SHIFT && o_mem_req.we) |->
                 ((CNT_W'(r_wr_idx) + 1'b1) < r_count), "shift write beyond list")
    `PLSD_ASSERT(a_result_hold, (r_state == S_RESULT) |=> $stable(r_count),
                 "count changed while a result waits")

endmodule

`default_nettype wire

// ===== sv/plsd_out.sv =====
// ----------------------------------------------------------------------------
// Packed list result register
// Holds one result for the output stream and packs its fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plsd_out (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_res_valid,
    output logic                                o_res_ready,
    input  plsd_pkg::t_result                   i_res,
    output logic                                o_tvalid,
    input  wire                                 i_tready,
    output logic [plsd_pkg::OUT_TDATA_W-1:0]    o_tdata
);
    import plsd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_res_ready = !r_valid || i_tready;
    assign o_tvalid    = r_valid;
    assign o_tdata     = OUT_TDATA_W'({r_res.count, r_res.position, r_res.found,
                                       r_res.status});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

// ===== sv/packed_list_insert_search_delete_unit.sv =====
// ----------------------------------------------------------------------------
// Packed list insert, search and delete unit
// Unsorted list of signed 32-bit values with append, first-match search and
// compacting delete, held in a single-port-pair entry store.
//
// Channel   Direction  Width  Contents
// s_axis    in         40     op, value
// m_axis    out        16     status, found, position, count
//
// Insert and unused op codes go from dispatch straight to the result.
// Search and delete scan the entries and stop at the first match, and the shift
// of a delete then reads only the later entries, one store read per cycle on
// the single read port.
// Reset clears the count and the control state; the store needs no clearing.
// A new input transfer is taken while the previous result waits on m_axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module packed_list_insert_search_delete_unit (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] op, [33:2] value, [39:34] zero
    input  wire  [plsd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [1:0] status, [2] found, [8:3] position, [15:9] count
    output logic [plsd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import plsd_pkg::*;

    t_mem_req          mem_req;
    logic [DATA_W-1:0] mem_rdata;
    logic              res_valid;
    logic              res_ready;
    t_result           res;

    plsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_op        (s_axis_tdata[OP_W-1:0]),
        .i_value     (s_axis_tdata[OP_W+DATA_W-1:OP_W]),
        .o_mem_req   (mem_req),
        .i_rdata     (mem_rdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    plsd_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    plsd_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .o_res_ready (res_ready),
        .i_res       (res),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== sim/packed_list_insert_search_delete_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Packed list insert, search and delete unit testbench
// Drives insert, search, delete and unused commands into the unit and checks
// every result against a queue-based model of the list. A directed opening
// covers the value extremes, duplicates and the not-found cases. It is
// followed by random command mixes that fill the list to capacity and drain it
// again, under three patterns of idling on the input and result streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packed_list_insert_search_delete_unit_tb;

    import plsd_pkg::*;

    typedef struct {
        t_op               op;
        logic [DATA_W-1:0] value;
    } t_list_cmd;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    t_list_cmd         cmd_backlog[$];
    t_result           awaited_results[$];
    logic [DATA_W-1:0] list_model[$];
    logic [DATA_W-1:0] recent_inserts[$];
    int                send_idle_pct = 21;
    int                recv_idle_pct = 58;
    int                mismatches = 0;

    logic [DATA_W-1:0] value_pool [8] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_002A
    };

    packed_list_insert_search_delete_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_result apply_list_cmd(input t_op op, input logic [DATA_W-1:0] value);
        t_result res;
        int      hit;
        res = '0;
        res.status = ST_OK;
        hit = -1;
        for (int i = 0; i < list_model.size() && hit < 0; i++)
            if (list_model[i] == value)
                hit = i;
        case (op)
            OP_INSERT: begin
                if (list_model.size() >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    res.position = POS_W'(list_model.size());
                    list_model.push_back(value);
                end
            end
            OP_SEARCH, OP_DELETE: begin
                if (hit < 0) begin
                    res.status = ST_MISSING;
                end else begin
                    res.found = 1'b1;
                    res.position = POS_W'(hit);
                    if (op == OP_DELETE)
                        list_model.delete(hit);
                end
            end
            default: ;
        endcase
        res.count = COUNT_W'(list_model.size());
        return res;
    endfunction

    task automatic push_cmd(input t_op op, input logic [DATA_W-1:0] value);
        t_list_cmd cmd;
        cmd.op = op;
        cmd.value = value;
        cmd_backlog.push_back(cmd);
        if (op == OP_INSERT) begin
            recent_inserts.push_back(value);
            if (recent_inserts.size() > CAPACITY)
                void'(recent_inserts.pop_front());
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_value(input bit from_history);
        int r;
        r = $urandom_range(99);
        if (from_history && recent_inserts.size() > 0 && r < 60)
            return recent_inserts[$urandom_range(recent_inserts.size() - 1)];
        if (r < (from_history ? 85 : 45))
            return value_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    task automatic queue_random_cmds(input int n_cmds, input int insert_pct,
                                     input int delete_pct);
        int r;
        for (int n = 0; n < n_cmds; n++) begin
            r = $urandom_range(99);
            if (r < insert_pct)
                push_cmd(OP_INSERT, pick_value(1'b0));
            else if (r < insert_pct + delete_pct)
                push_cmd(OP_DELETE, pick_value(1'b1));
            else if (r < 96)
                push_cmd(OP_SEARCH, pick_value(1'b1));
            else
                push_cmd(OP_NONE, $urandom);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic wait_for_drain();
        while (cmd_backlog.size() > 0 || s_axis_tvalid || awaited_results.size() > 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : cmd_driver
        t_list_cmd nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                awaited_results.push_back(apply_list_cmd(t_op'(s_axis_tdata[OP_W-1:0]),
                                                         s_axis_tdata[OP_W +: DATA_W]));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = cmd_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {{(IN_TDATA_W - OP_W - DATA_W){1'b0}}, nxt.value, nxt.op};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tdata 0x%h",
                         $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                check_field("status", want.status, m_axis_tdata[ST_W-1:0]);
                check_field("found", want.found, m_axis_tdata[ST_W]);
                check_field("position", want.position, m_axis_tdata[ST_W+1 +: POS_W]);
                check_field("count", want.count, m_axis_tdata[ST_W+1+POS_W +: COUNT_W]);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_cmd(OP_SEARCH, 32'h0000_0000);
        push_cmd(OP_DELETE, 32'hFFFF_FFFF);
        push_cmd(OP_INSERT, 32'h7FFF_FFFF);
        push_cmd(OP_INSERT, 32'h8000_0000);
        push_cmd(OP_INSERT, 32'h0000_0000);
        push_cmd(OP_INSERT, 32'hFFFF_FFFF);
        push_cmd(OP_INSERT, 32'h8000_0000);
        push_cmd(OP_SEARCH, 32'h8000_0000);
        push_cmd(OP_SEARCH, 32'hFFFF_FFFF);
        push_cmd(OP_SEARCH, 32'h7FFF_FFFE);
        push_cmd(OP_DELETE, 32'h8000_0000);
        push_cmd(OP_SEARCH, 32'h8000_0000);
        push_cmd(OP_DELETE, 32'h1234_5678);
        push_cmd(OP_NONE, 32'hDEAD_BEEF);
        push_cmd(OP_DELETE, 32'h7FFF_FFFF);
        push_cmd(OP_DELETE, 32'h8000_0000);
        push_cmd(OP_DELETE, 32'hFFFF_FFFF);
        push_cmd(OP_DELETE, 32'h0000_0000);
        push_cmd(OP_DELETE, 32'h0000_0000);
        push_cmd(OP_NONE, 32'h0000_0000);

        for (int phase = 0; phase < 3; phase++) begin
            for (int seg = 0; seg < 4; seg++) begin
                if (seg % 2 == 0)
                    queue_random_cmds(143, 70, 12);
                else
                    queue_random_cmds(143, 20, 60);
            end
            wait_for_drain();
            if (phase == 0) begin
                send_idle_pct = 58;
                recv_idle_pct = 21;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end

        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/plsd_pkg.sv
sv/plsd_ram.sv
sv/plsd_ctrl.sv
sv/plsd_out.sv
sv/packed_list_insert_search_delete_unit.sv
sim/packed_list_insert_search_delete_unit_tb.sv
